// File: src/hmbr_pkg.sv
// ----------------------------------------------------------------------------
// Heightmap brush package
// Shared types, constants and codes of the heightmap brush block.
// ----------------------------------------------------------------------------
package hmbr_pkg;

	// Default grid side and radius limits.
	localparam int MAP_SIDE_DEF      = 256;
	localparam int MAX_BRUSH_RADIUS  = 4;
	localparam int MAX_SMOOTH_RADIUS = 3;

	// Pending result store: at most (2r)^2 cells per brush.
	localparam int MAX_CELLS = (2 * MAX_BRUSH_RADIUS) * (2 * MAX_BRUSH_RADIUS);
	localparam int PEND_AW   = $clog2(MAX_CELLS);
	localparam int PEND_CW   = PEND_AW + 1;

	// Signed width of grid coordinates inside the brush datapath.
	localparam int CW = 12;

	// Height limits, Q15.8.
	localparam int HMAX = 8388607;
	localparam int HMIN = -8388608;

	// Rounding divider widths: signed numerator, unsigned denominator.
	localparam int DIV_NW = 47;
	localparam int DIV_DW = 24;
	localparam int DIV_QW = DIV_NW + 1;

	// Commands.
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_BRUSH = 2'd2
	} cmd_e;

	// Configuration register indexes.
	localparam logic [2:0] CFG_BRUSH_RADIUS   = 3'd0;
	localparam logic [2:0] CFG_BRUSH_STRENGTH = 3'd1;
	localparam logic [2:0] CFG_SMOOTH_RADIUS  = 3'd2;
	localparam logic [2:0] CFG_MAP_WIDTH      = 3'd3;
	localparam logic [2:0] CFG_MAP_DEPTH      = 3'd4;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE,
		S_CMD,
		S_RD_LD,
		S_B_CELL,
		S_B_SQ,
		S_B_CMP,
		S_B_M1,
		S_B_M2,
		S_B_DS1,
		S_B_DW1,
		S_B_NB,
		S_B_NBD,
		S_B_DS2,
		S_B_DW2,
		S_B_NEXT,
		S_D_RD,
		S_D_LD
	} state_t;

	// Request payload.
	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         cell_x;
		logic [7:0]         cell_z;
		logic signed [23:0] height_in;
		logic [15:0]        point_x;
		logic [15:0]        point_z;
		logic signed [15:0] force_req;
	} in_req_t;

	// Result payload.
	typedef struct packed {
		logic [7:0]         out_x;
		logic [7:0]         out_z;
		logic signed [23:0] out_height;
		logic               status;
		logic               last;
	} out_res_t;

	// One pending brush result.
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] z;
		logic signed [23:0]   h;
	} pend_t;

endpackage

// File: src/hmbr_div.sv
// ----------------------------------------------------------------------------
// Rounding divider
// Signed by unsigned division, rounded to nearest with ties away from zero,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hmbr_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [hmbr_pkg::DIV_NW-1:0]   num,
	input  logic [hmbr_pkg::DIV_DW-1:0]          den,
	output logic                                 done,
	output logic signed [hmbr_pkg::DIV_QW:0]     quo
);
	localparam int NW = hmbr_pkg::DIV_NW;
	localparam int DW = hmbr_pkg::DIV_DW;
	localparam int QW = hmbr_pkg::DIV_QW;
	localparam int KW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [KW-1:0] cnt_q;
	logic [QW-1:0] dvd_q;
	logic [DW:0]   dvs_q;
	logic [DW:0]   rem_q;
	logic          neg_q;
	logic [NW-1:0] mag;
	logic [DW+1:0] trial;
	logic          fits;

	// Magnitude of the numerator and the trial subtraction of this step.
	always_comb begin
		mag   = num[NW-1] ? NW'(-num) : NW'(num);
		trial = {rem_q, dvd_q[QW-1]};
		fits  = trial >= (DW + 2)'(dvs_q);
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division of (2|num| + den) by 2*den; the quotient shifts into dvd_q.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= QW'({mag, 1'b0}) + QW'(den);
			dvs_q <= {den, 1'b0};
			rem_q <= '0;
			neg_q <= num[NW-1];
		end else if (busy_q) begin
			rem_q <= fits ? (DW + 1)'(trial - (DW + 2)'(dvs_q)) : trial[DW:0];
			dvd_q <= {dvd_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});

endmodule

// File: src/heightmap_brush_raise_smooth.sv
// ----------------------------------------------------------------------------
// Heightmap brush, raise and smooth
// Grid of Q15.8 heights with write, read and circular brush commands.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall, results leave on out_valid/out_stall;
// a transfer happens on a clock edge with valid high and stall low.
// The configuration port writes one register per edge with cfg_we high.
// One request is worked at a time; in_stall is low only while idle, and a new
// request may enter while the last result still waits in the output register.
// A write returns nothing. A read returns one result with last set.
// A brush visits the 2r by 2r cells around the point. Cells outside the map
// or the radius are skipped; a cell that is kept takes two passes through
// the bit-serial divider and one height-memory read per neighbor. Results
// are emitted afterwards and written back to the height memory as they
// leave. The height memory read port bounds the neighbor sweep.
// Reset loads the register defaults and idles the sequencer; the height
// memory is not cleared. While a result waits in the output register and
// out_stall is high, the sequencer holds before loading the next result.
// ----------------------------------------------------------------------------
module heightmap_brush_raise_smooth #(
	parameter int MAP_SIDE = hmbr_pkg::MAP_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  hmbr_pkg::in_req_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output hmbr_pkg::out_res_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [8:0]         cfg_data
);
	localparam int CW  = hmbr_pkg::CW;
	localparam int AW  = $clog2(MAP_SIDE * MAP_SIDE);
	localparam int DXW = 13;
	localparam int OW  = 4;
	localparam int PAW = hmbr_pkg::PEND_AW;
	localparam int PCW = hmbr_pkg::PEND_CW;
	localparam int NW  = hmbr_pkg::DIV_NW;
	localparam int DW  = hmbr_pkg::DIV_DW;
	localparam int QW  = hmbr_pkg::DIV_QW;
	localparam logic signed [QW:0] Q_MAX = (QW + 1)'(hmbr_pkg::HMAX);
	localparam logic signed [QW:0] Q_MIN = (QW + 1)'(hmbr_pkg::HMIN);

	// Configuration registers.
	logic [2:0] radius_q;
	logic [7:0] strength_q;
	logic [1:0] smooth_q;
	logic [8:0] width_q;
	logic [8:0] depth_q;

	// Sequencer and datapath registers.
	hmbr_pkg::state_t  state_q, state_d;
	hmbr_pkg::in_req_t req_q;
	hmbr_pkg::out_res_t out_q, out_next;
	logic              out_vld_q;
	logic signed [CW-1:0] xb_q, zb_q, x_q, z_q, nbx_q, nbz_q;
	logic [OW-1:0]     ox_q, oz_q, ni_q, nj_q;
	logic signed [DXW-1:0] dx_q, dz_q;
	logic [2*DXW-1:0]  dxx_q, dzz_q;
	logic [20:0]       diff_q;
	logic signed [37:0] p1_q;
	logic signed [46:0] p2_q;
	logic signed [23:0] old_q;
	logic signed [31:0] sum_q;
	logic [5:0]        cnt_q;
	logic [PCW-1:0]    n_q;
	logic [PAW-1:0]    k_q;
	logic              nb_vld_s1;

	// Memories.
	logic signed [23:0] hmem [MAP_SIDE * MAP_SIDE];
	logic signed [23:0] st_rd_q;
	hmbr_pkg::pend_t    pmem [hmbr_pkg::MAX_CELLS];
	hmbr_pkg::pend_t    pd_rd_q;

	// Control strobes.
	logic               st_re, st_we, pd_re, pd_we, out_load, div_start, div_done;
	logic [AW-1:0]      st_raddr, st_waddr;
	logic signed [23:0] st_wdata;
	logic signed [NW-1:0] div_num;
	logic [DW-1:0]      div_den;
	logic signed [QW:0] div_quo;

	// Derived values.
	logic [2:0]         r_c, s_c;
	logic signed [CW-1:0] w_c, d_c;
	logic [5:0]         rr;
	logic [7:0]         rr10;
	logic [2*DXW:0]     r2_w, d2_w;
	logic signed [CW-1:0] cx_w, cz_w, cur_x, cur_z, nb_x, nb_z;
	logic signed [CW+7:0] dx_full, dz_full;
	logic               cell_ok, nb_ok, cmd_ok, out_free, cell_end, nb_end, pend_last;
	logic signed [25:0] h1_w;
	logic signed [23:0] hsat_w;

	function automatic logic in_map(input logic signed [CW-1:0] a, input logic signed [CW-1:0] b,
			input logic signed [CW-1:0] wl, input logic signed [CW-1:0] dl);
		return !a[CW-1] && !b[CW-1] && (a < wl) && (b < dl);
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		return AW'(32'(unsigned'(b)) * MAP_SIDE + 32'(unsigned'(a)));
	endfunction

	// Clamped registers and cell geometry.
	always_comb begin
		if (radius_q == '0)
			r_c = 3'd1;
		else if (32'(radius_q) > hmbr_pkg::MAX_BRUSH_RADIUS)
			r_c = 3'(hmbr_pkg::MAX_BRUSH_RADIUS);
		else
			r_c = radius_q;
		if (32'(smooth_q) > hmbr_pkg::MAX_SMOOTH_RADIUS)
			s_c = 3'(hmbr_pkg::MAX_SMOOTH_RADIUS);
		else
			s_c = 3'(smooth_q);
		if (width_q == '0)
			w_c = CW'(1);
		else if (32'(width_q) > MAP_SIDE)
			w_c = CW'(MAP_SIDE);
		else
			w_c = CW'(width_q);
		if (depth_q == '0)
			d_c = CW'(1);
		else if (32'(depth_q) > MAP_SIDE)
			d_c = CW'(MAP_SIDE);
		else
			d_c = CW'(depth_q);
		rr       = 6'(r_c * r_c);
		rr10     = 8'(rr * 8'd10);
		r2_w     = (2 * DXW + 1)'({rr, 16'h0000});
		d2_w     = (2 * DXW + 1)'(dxx_q) + (2 * DXW + 1)'(dzz_q);
		cx_w     = CW'(req_q.cell_x);
		cz_w     = CW'(req_q.cell_z);
		cmd_ok   = in_map(cx_w, cz_w, w_c, d_c);
		cur_x    = xb_q + CW'(ox_q);
		cur_z    = zb_q + CW'(oz_q);
		cell_ok  = in_map(cur_x, cur_z, w_c, d_c);
		dx_full  = $signed({cur_x, 8'h00}) - $signed({4'h0, req_q.point_x});
		dz_full  = $signed({cur_z, 8'h00}) - $signed({4'h0, req_q.point_z});
		nb_x     = nbx_q + CW'(ni_q);
		nb_z     = nbz_q + CW'(nj_q);
		nb_ok    = in_map(nb_x, nb_z, w_c, d_c);
		cell_end = (ox_q == OW'(2 * r_c - 1)) && (oz_q == OW'(2 * r_c - 1));
		nb_end   = (ni_q == OW'(2 * s_c)) && (nj_q == OW'(2 * s_c));
		out_free = !out_vld_q || !out_stall;
		pend_last = (PCW'(k_q) + PCW'(1)) == n_q;
		h1_w     = 26'(old_q) + 26'(div_quo);
		if (div_quo > Q_MAX)
			hsat_w = 24'(hmbr_pkg::HMAX);
		else if (div_quo < Q_MIN)
			hsat_w = 24'(hmbr_pkg::HMIN);
		else
			hsat_w = 24'(div_quo);
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= 3'd4;
			strength_q <= 8'd1;
			smooth_q   <= 2'd0;
			width_q    <= 9'd256;
			depth_q    <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hmbr_pkg::CFG_BRUSH_RADIUS:   radius_q   <= cfg_data[2:0];
				hmbr_pkg::CFG_BRUSH_STRENGTH: strength_q <= cfg_data[7:0];
				hmbr_pkg::CFG_SMOOTH_RADIUS:  smooth_q   <= cfg_data[1:0];
				hmbr_pkg::CFG_MAP_WIDTH:      width_q    <= cfg_data;
				hmbr_pkg::CFG_MAP_DEPTH:      depth_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state and memory, divider and output strobes.
	always_comb begin
		state_d   = state_q;
		st_re     = 1'b0;
		st_raddr  = '0;
		st_we     = 1'b0;
		st_waddr  = '0;
		st_wdata  = '0;
		pd_re     = 1'b0;
		pd_we     = 1'b0;
		out_load  = 1'b0;
		out_next  = '0;
		div_start = 1'b0;
		div_num   = NW'(p2_q);
		div_den   = DW'({rr10, 16'h0000});
		unique case (state_q)
			hmbr_pkg::S_IDLE: begin
				if (in_valid)
					state_d = hmbr_pkg::S_CMD;
			end
			hmbr_pkg::S_CMD: begin
				unique case (req_q.command)
					hmbr_pkg::CMD_WRITE: begin
						st_we    = cmd_ok;
						st_waddr = cell_addr(cx_w, cz_w);
						st_wdata = req_q.height_in;
						state_d  = hmbr_pkg::S_IDLE;
					end
					hmbr_pkg::CMD_READ: begin
						st_re    = cmd_ok;
						st_raddr = cell_addr(cx_w, cz_w);
						state_d  = hmbr_pkg::S_RD_LD;
					end
					hmbr_pkg::CMD_BRUSH: state_d = hmbr_pkg::S_B_CELL;
					default: state_d = hmbr_pkg::S_IDLE;
				endcase
			end
			hmbr_pkg::S_RD_LD: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next.out_x = req_q.cell_x;
					out_next.out_z = req_q.cell_z;
					out_next.out_height = cmd_ok ? st_rd_q : 24'sd0;
					out_next.status = !cmd_ok;
					out_next.last = 1'b1;
					state_d = hmbr_pkg::S_IDLE;
				end
			end
			hmbr_pkg::S_B_CELL: begin
				st_re    = cell_ok;
				st_raddr = cell_addr(cur_x, cur_z);
				state_d  = cell_ok ? hmbr_pkg::S_B_SQ : hmbr_pkg::S_B_NEXT;
			end
			hmbr_pkg::S_B_SQ: state_d = hmbr_pkg::S_B_CMP;
			hmbr_pkg::S_B_CMP: state_d = (d2_w > r2_w) ? hmbr_pkg::S_B_NEXT : hmbr_pkg::S_B_M1;
			hmbr_pkg::S_B_M1: state_d = hmbr_pkg::S_B_M2;
			hmbr_pkg::S_B_M2: state_d = hmbr_pkg::S_B_DS1;
			hmbr_pkg::S_B_DS1: begin
				div_start = 1'b1;
				state_d   = hmbr_pkg::S_B_DW1;
			end
			hmbr_pkg::S_B_DW1: begin
				if (div_done)
					state_d = hmbr_pkg::S_B_NB;
			end
			hmbr_pkg::S_B_NB: begin
				st_re    = nb_ok;
				st_raddr = cell_addr(nb_x, nb_z);
				if (nb_end)
					state_d = hmbr_pkg::S_B_NBD;
			end
			hmbr_pkg::S_B_NBD: state_d = hmbr_pkg::S_B_DS2;
			hmbr_pkg::S_B_DS2: begin
				div_start = 1'b1;
				div_num   = NW'(sum_q);
				div_den   = DW'(cnt_q);
				state_d   = hmbr_pkg::S_B_DW2;
			end
			hmbr_pkg::S_B_DW2: begin
				if (div_done) begin
					pd_we   = 1'b1;
					state_d = hmbr_pkg::S_B_NEXT;
				end
			end
			hmbr_pkg::S_B_NEXT: begin
				if (!cell_end)
					state_d = hmbr_pkg::S_B_CELL;
				else if (n_q == '0)
					state_d = hmbr_pkg::S_IDLE;
				else
					state_d = hmbr_pkg::S_D_RD;
			end
			hmbr_pkg::S_D_RD: begin
				pd_re   = 1'b1;
				state_d = hmbr_pkg::S_D_LD;
			end
			hmbr_pkg::S_D_LD: begin
				if (out_free) begin
					out_load = 1'b1;
					out_next.out_x = pd_rd_q.x[7:0];
					out_next.out_z = pd_rd_q.z[7:0];
					out_next.out_height = pd_rd_q.h;
					out_next.status = 1'b0;
					out_next.last = pend_last;
					st_we    = 1'b1;
					st_waddr = cell_addr(pd_rd_q.x, pd_rd_q.z);
					st_wdata = pd_rd_q.h;
					state_d  = pend_last ? hmbr_pkg::S_IDLE : hmbr_pkg::S_D_RD;
				end
			end
			default: state_d = hmbr_pkg::S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hmbr_pkg::S_IDLE;
			out_vld_q <= 1'b0;
			nb_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			nb_vld_s1 <= (state_q == hmbr_pkg::S_B_NB) && nb_ok;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (!out_stall)
				out_vld_q <= 1'b0;
		end
	end

	// Brush datapath.
	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= out_next;
		case (state_q)
			hmbr_pkg::S_IDLE: begin
				if (in_valid)
					req_q <= in_data;
			end
			hmbr_pkg::S_CMD: begin
				xb_q <= $signed(CW'(req_q.point_x[15:8])) - $signed(CW'(r_c));
				zb_q <= $signed(CW'(req_q.point_z[15:8])) - $signed(CW'(r_c));
				ox_q <= '0;
				oz_q <= '0;
				n_q  <= '0;
			end
			hmbr_pkg::S_B_CELL: begin
				x_q  <= cur_x;
				z_q  <= cur_z;
				dx_q <= DXW'(dx_full);
				dz_q <= DXW'(dz_full);
			end
			hmbr_pkg::S_B_SQ: begin
				old_q <= st_rd_q;
				dxx_q <= (2 * DXW)'(dx_q * dx_q);
				dzz_q <= (2 * DXW)'(dz_q * dz_q);
			end
			hmbr_pkg::S_B_CMP: diff_q <= 21'(r2_w - d2_w);
			hmbr_pkg::S_B_M1: p1_q <= req_q.force_req * $signed({1'b0, diff_q});
			hmbr_pkg::S_B_M2: p2_q <= 47'(p1_q * $signed({1'b0, strength_q}));
			hmbr_pkg::S_B_DW1: begin
				if (div_done) begin
					sum_q <= 32'(h1_w);
					cnt_q <= 6'd1;
					nbx_q <= x_q - $signed(CW'(s_c));
					nbz_q <= z_q - $signed(CW'(s_c));
					ni_q  <= '0;
					nj_q  <= '0;
				end
			end
			hmbr_pkg::S_B_NB: begin
				if (nb_ok)
					cnt_q <= cnt_q + 6'd1;
				if (nj_q == OW'(2 * s_c)) begin
					nj_q <= '0;
					ni_q <= ni_q + 1'b1;
				end else begin
					nj_q <= nj_q + 1'b1;
				end
			end
			hmbr_pkg::S_B_DW2: begin
				if (div_done)
					n_q <= n_q + 1'b1;
			end
			hmbr_pkg::S_B_NEXT: begin
				k_q <= '0;
				if (oz_q == OW'(2 * r_c - 1)) begin
					oz_q <= '0;
					ox_q <= ox_q + 1'b1;
				end else begin
					oz_q <= oz_q + 1'b1;
				end
			end
			hmbr_pkg::S_D_LD: begin
				if (out_free && !pend_last)
					k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
		// Neighbor heights arrive in the cycle after their read.
		if (nb_vld_s1)
			sum_q <= sum_q + 32'(st_rd_q);
	end

	// Height memory.
	always_ff @(posedge clk) begin
		if (st_we)
			hmem[st_waddr] <= st_wdata;
		if (st_re)
			st_rd_q <= hmem[st_raddr];
	end

	// Pending result memory.
	always_ff @(posedge clk) begin
		if (pd_we)
			pmem[n_q[PAW-1:0]] <= '{x: x_q, z: z_q, h: hsat_w};
		if (pd_re)
			pd_rd_q <= pmem[k_q];
	end

	hmbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign in_stall  = (state_q != hmbr_pkg::S_IDLE);
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// File: src/hmbr_chk.sv
// ----------------------------------------------------------------------------
// Heightmap brush port checker
// Checks the result channel of the heightmap brush block over time.
// ----------------------------------------------------------------------------
module hmbr_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input hmbr_pkg::out_res_t out_data
);

	// A stalled result stays and does not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// A result only goes away after it was taken.
	a_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without transfer");

	// An out-of-map read ends its command.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.last)
		else $error("error result without last");

	// An out-of-map read reports zero height.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status |-> out_data.out_height == 24'sd0)
		else $error("error result with nonzero height");

endmodule

bind heightmap_brush_raise_smooth hmbr_chk u_hmbr_chk (.*);

// File: verif/tb_heightmap_brush_raise_smooth.sv
// ----------------------------------------------------------------------------
// Heightmap brush testbench
// Drives write, read and brush requests through the valid/stall channel and
// checks every result against an in-bench model of the height grid. The run
// steps through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_heightmap_brush_raise_smooth;
	import hmbr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_CYCLES    = 400;
	// Side of the block of cells that is written before anything is read.
	localparam int SEED_SIDE      = 20;
	localparam int POINT_SPAN     = 12 * 256;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	in_req_t  in_data;
	logic     out_valid;
	logic     out_stall;
	out_res_t out_data;
	logic     cfg_we;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;

	heightmap_brush_raise_smooth u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock, 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Grid model and register copies.
	logic signed [23:0] grid_height [0:65535];
	bit                 grid_written [0:65535];
	logic [2:0] m_radius;
	logic [7:0] m_strength;
	logic [1:0] m_smooth;
	logic [8:0] m_width;
	logic [8:0] m_depth;

	in_req_t  request_q [$];
	out_res_t height_expect_q [$];
	int err_cnt = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	logic req_taken;

	function automatic longint div_round(longint num, longint den);
		if (num >= 0)
			return (2 * num + den) / (2 * den);
		return -((-2 * num + den) / (2 * den));
	endfunction

	function automatic longint sat_height(longint h);
		if (h > HMAX)
			return HMAX;
		if (h < HMIN)
			return HMIN;
		return h;
	endfunction

	// Works out the results of one request. Only a request that reads no
	// unwritten cell is legal; the model changes only for a legal one.
	task automatic predict_request(input in_req_t rq, output bit legal);
		int w, dp, r, s, x0, x1, z0, z1, n, px, pz;
		longint r2, dx, dz, d2, h, sum, cnt, frc;
		int cx, cz;
		int nx [0:63];
		int nz [0:63];
		longint nh [0:63];
		out_res_t res;
		w  = (m_width == 0) ? 1 : ((m_width > 256) ? 256 : int'(m_width));
		dp = (m_depth == 0) ? 1 : ((m_depth > 256) ? 256 : int'(m_depth));
		cx = rq.cell_x;
		cz = rq.cell_z;
		legal = 1'b1;
		case (rq.command)
			CMD_WRITE: begin
				if (cx < w && cz < dp) begin
					grid_height[cz * 256 + cx] = rq.height_in;
					grid_written[cz * 256 + cx] = 1'b1;
				end
			end
			CMD_READ: begin
				res.out_x = rq.cell_x;
				res.out_z = rq.cell_z;
				res.last = 1'b1;
				if (cx < w && cz < dp) begin
					legal = grid_written[cz * 256 + cx];
					res.out_height = grid_height[cz * 256 + cx];
					res.status = 1'b0;
				end else begin
					res.out_height = '0;
					res.status = 1'b1;
				end
				if (legal)
					height_expect_q.push_back(res);
			end
			CMD_BRUSH: begin
				r = (m_radius < 1) ? 1 : ((m_radius > 4) ? 4 : int'(m_radius));
				s = m_smooth;
				px = rq.point_x;
				pz = rq.point_z;
				frc = rq.force_req;
				r2 = longint'(r) * r * 65536;
				x0 = (px - r * 256) >>> 8;
				x1 = (px + r * 256) >>> 8;
				z0 = (pz - r * 256) >>> 8;
				z1 = (pz + r * 256) >>> 8;
				n = 0;
				for (int x = x0; x < x1; x++) begin
					for (int z = z0; z < z1; z++) begin
						if (x < 0 || z < 0 || x >= w || z >= dp)
							continue;
						dx = longint'(x) * 256 - px;
						dz = longint'(z) * 256 - pz;
						d2 = dx * dx + dz * dz;
						if (d2 > r2)
							continue;
						if (!grid_written[z * 256 + x])
							legal = 1'b0;
						h = grid_height[z * 256 + x];
						h += div_round(frc * (r2 - d2) * longint'(m_strength), r2 * 10);
						sum = h;
						cnt = 1;
						for (int i = x - s; i <= x + s; i++)
							for (int j = z - s; j <= z + s; j++)
								if (i >= 0 && j >= 0 && i < w && j < dp) begin
									if (!grid_written[j * 256 + i])
										legal = 1'b0;
									sum += grid_height[j * 256 + i];
									cnt++;
								end
						nx[n] = x;
						nz[n] = z;
						nh[n] = sat_height(div_round(sum, cnt));
						n++;
					end
				end
				if (legal) begin
					// Write-back happens only after every cell has been worked.
					for (int k = 0; k < n; k++) begin
						res.out_x = nx[k][7:0];
						res.out_z = nz[k][7:0];
						res.out_height = nh[k][23:0];
						res.status = 1'b0;
						res.last = (k == n - 1);
						height_expect_q.push_back(res);
						grid_height[nz[k] * 256 + nx[k]] = nh[k][23:0];
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic queue_request(input in_req_t rq, output bit legal);
		predict_request(rq, legal);
		if (legal)
			request_q.push_back(rq);
	endtask

	task automatic send(input in_req_t rq);
		bit ok;
		queue_request(rq, ok);
	endtask

	function automatic in_req_t any_fields();
		in_req_t rq;
		rq = {$urandom, $urandom, $urandom, $urandom};
		return rq;
	endfunction

	function automatic in_req_t brush_at(int px, int pz, int frc);
		in_req_t rq;
		rq = any_fields();
		rq.command = CMD_BRUSH;
		rq.point_x = px[15:0];
		rq.point_z = pz[15:0];
		rq.force_req = frc[15:0];
		return rq;
	endfunction

	function automatic in_req_t cell_cmd(logic [1:0] cmd, int x, int z, int h);
		in_req_t rq;
		rq = any_fields();
		rq.command = cmd;
		rq.cell_x = x[7:0];
		rq.cell_z = z[7:0];
		rq.height_in = h[23:0];
		return rq;
	endfunction

	// Random mix, mostly well-formed requests inside the written block.
	task automatic random_requests(input int count);
		in_req_t rq;
		bit ok;
		int sel, tries;
		for (int k = 0; k < count; k++) begin
			ok = 1'b0;
			tries = 0;
			while (!ok && tries < 20) begin
				rq = any_fields();
				sel = $urandom_range(99);
				if (sel < 30) begin
					rq.command = CMD_WRITE;
					if ($urandom_range(99) < 70) begin
						rq.cell_x = $urandom_range(SEED_SIDE - 1);
						rq.cell_z = $urandom_range(SEED_SIDE - 1);
					end
				end else if (sel < 55) begin
					rq.command = CMD_READ;
					if ($urandom_range(99) < 75) begin
						rq.cell_x = $urandom_range(SEED_SIDE - 1);
						rq.cell_z = $urandom_range(SEED_SIDE - 1);
					end
				end else if (sel < 95) begin
					rq.command = CMD_BRUSH;
					if ($urandom_range(99) < 80) begin
						rq.point_x = $urandom_range(POINT_SPAN - 1);
						rq.point_z = $urandom_range(POINT_SPAN - 1);
					end
				end else begin
					rq.command = CMD_UNUSED;
				end
				queue_request(rq, ok);
				tries++;
			end
			if (!ok)
				send(cell_cmd(CMD_READ, 0, 0, 0));
		end
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [8:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BRUSH_RADIUS:   m_radius = val[2:0];
			CFG_BRUSH_STRENGTH: m_strength = val[7:0];
			CFG_SMOOTH_RADIUS:  m_smooth = val[1:0];
			CFG_MAP_WIDTH:      m_width = val;
			CFG_MAP_DEPTH:      m_depth = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [8:0] r, input logic [8:0] st, input logic [8:0] s,
			input logic [8:0] w, input logic [8:0] d);
		cfg_write(CFG_BRUSH_RADIUS, r);
		cfg_write(CFG_BRUSH_STRENGTH, st);
		cfg_write(CFG_SMOOTH_RADIUS, s);
		cfg_write(CFG_MAP_WIDTH, w);
		cfg_write(CFG_MAP_DEPTH, d);
	endtask

	// Waits until every request is taken and every result has arrived, then
	// lets a trailing write finish inside the block.
	task automatic drain();
		wait (request_q.size() == 0 && !in_valid && height_expect_q.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		err_cnt++;
	endtask

	// Request driver, fed from the pending queue.
	always @(posedge clk)
		req_taken <= in_valid && !in_stall;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !req_taken) begin
			// Stalled request holds.
		end else if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			in_data <= request_q.pop_front();
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result receiver stall, with an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (height_expect_q.size() == 0) begin
				$display("unexpected result at x %0d z %0d", out_data.out_x, out_data.out_z);
				err_cnt++;
			end else begin
				out_res_t want;
				want = height_expect_q.pop_front();
				if (out_data.out_x !== want.out_x)
					report_mismatch("out_x", out_data.out_x, want.out_x);
				if (out_data.out_z !== want.out_z)
					report_mismatch("out_z", out_data.out_z, want.out_z);
				if (out_data.out_height !== want.out_height)
					report_mismatch("out_height", out_data.out_height, want.out_height);
				if (out_data.status !== want.status)
					report_mismatch("status", out_data.status, want.status);
				if (out_data.last !== want.last)
					report_mismatch("last", out_data.last, want.last);
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_heightmap_brush_raise_smooth failed");
			$finish;
		end
	end

	// Stimulus and phase sequencing.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_radius = 3'd4;
		m_strength = 8'd1;
		m_smooth = 2'd0;
		m_width = 9'd256;
		m_depth = 9'd256;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill the working block of cells, extremes included.
		for (int z = 0; z < SEED_SIDE; z++)
			for (int x = 0; x < SEED_SIDE; x++)
				send(cell_cmd(CMD_WRITE, x, z, $urandom));
		send(cell_cmd(CMD_WRITE, 3, 3, HMAX));
		send(cell_cmd(CMD_WRITE, 4, 3, HMIN));
		send(cell_cmd(CMD_WRITE, 255, 255, 0));

		// Reset settings, no idling.
		send(cell_cmd(CMD_READ, 0, 0, 0));
		send(cell_cmd(CMD_READ, 19, 19, 0));
		send(cell_cmd(CMD_READ, 255, 255, 0));
		send(cell_cmd(CMD_UNUSED, 255, 255, -1));
		send(brush_at(0, 0, 32767));
		send(brush_at(5 * 256 + 128, 7 * 256 + 77, -32768));
		send(brush_at(3 * 256 + 128, 3 * 256 + 128, 32767));
		random_requests(20);
		drain();

		// Smallest radius, full strength, widest smoothing, small map.
		set_regs(9'd1, 9'd255, 9'd3, 9'd20, 9'd20);
		send_idle_pct = 45;
		send(cell_cmd(CMD_WRITE, 3, 3, HMAX));
		send(cell_cmd(CMD_READ, 255, 255, 0));
		send(cell_cmd(CMD_WRITE, 200, 5, 1234));
		send(cell_cmd(CMD_READ, 200, 5, 0));
		send(brush_at(65535, 65535, 32767));
		send(brush_at(3 * 256, 3 * 256, 32767));
		send(brush_at(4 * 256, 3 * 256, -32768));
		random_requests(22);
		drain();

		// Zero strength, full map, receiver stalling.
		set_regs(9'd2, 9'd0, 9'd1, 9'd256, 9'd256);
		send_idle_pct = 0;
		recv_stall_pct = 45;
		random_requests(22);
		drain();

		// Largest radius on a one-cell map, both sides idling.
		set_regs(9'd4, 9'd128, 9'd2, 9'd1, 9'd1);
		send_idle_pct = 18;
		recv_stall_pct = 18;
		send(brush_at(0, 0, 32767));
		send(cell_cmd(CMD_READ, 1, 0, 0));
		random_requests(20);
		drain();

		// Out-of-range register values, no idling.
		set_regs(9'h1F8, 9'h1FF, 9'h1FF, 9'd300, 9'd0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_requests(22);
		drain();

		// Long receiver hold-off while requests keep coming.
		set_regs(9'd3, 9'd10, 9'd0, 9'd17, 9'd13);
		send_idle_pct = 18;
		recv_stall_pct = 18;
		hold_requests = hold_requests + 1;
		random_requests(22);
		drain();

		if (err_cnt == 0 && height_expect_q.size() == 0)
			$display("tb_heightmap_brush_raise_smooth passed");
		else
			$display("tb_heightmap_brush_raise_smooth failed");
		$finish;
	end

endmodule

// File: filelist.f
src/hmbr_pkg.sv
src/hmbr_div.sv
src/heightmap_brush_raise_smooth.sv
src/hmbr_chk.sv
verif/tb_heightmap_brush_raise_smooth.sv
